// ===== src/hlrp_pkg.sv =====
// ============================================================================
// hlrp_pkg - shared types, constants and helpers of the response parser
// Character codes, status codes, the state encodings and the structs that
// pass between the front end, the command queue and the back end.
// ============================================================================
package hlrp_pkg;

	// Default word buffer depth of one frame
	localparam int MAX_WORDS_DEF = 16;
	// Word counter width, wide enough for the largest supported depth (63)
	localparam int WCNT_W = 6;
	// Depth of the frame-end command queue
	localparam int CMDQ_DEPTH = 2;

	localparam logic [7:0] CH_AT   = 8'h40;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_R    = 8'h52;
	localparam logic [7:0] CH_W    = 8'h57;

	typedef enum logic [3:0] {
		ST_READ     = 4'd0,
		ST_WRITE    = 4'd1,
		ST_FORMAT   = 4'd2,
		ST_CHECK    = 4'd3,
		ST_ENDCODE  = 4'd4,
		ST_HEADER   = 4'd5,
		ST_LENGTH   = 4'd6,
		ST_HEX      = 4'd7,
		ST_OVERFLOW = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEAD,
		PH_BODY,
		PH_STAR
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_LOAD,
		BK_STATUS
	} back_state_t;

	typedef struct packed {
		logic [7:0] rx_char;
	} rx_item_t;

	typedef struct packed {
		logic        is_word;
		logic [15:0] word_value;
		logic [3:0]  word_index;
		logic [3:0]  status;
		logic        last;
	} result_t;

	// One finished frame, as handed from the front end to the back end
	typedef struct packed {
		logic              bank;
		logic [WCNT_W-1:0] nwords;
		logic              emit;
		status_t           status;
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic              bank;
		logic [WCNT_W-1:0] idx;
		logic [15:0]       data;
	} word_wr_t;

	typedef struct packed {
		logic en;
		logic bank;
	} done_t;

	// Bit 4 is set when the character is a hex digit of either case
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	function automatic logic [7:0] hex_upper(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'd0, n};
		end else begin
			r = 8'h37 + {4'd0, n};
		end
		return r;
	endfunction

	// Keep the lowest error code seen; ST_READ stands for no error yet
	function automatic status_t flag_err(input status_t cur, input status_t code);
		status_t r;
		r = cur;
		if (cur == ST_READ || code < cur) begin
			r = code;
		end
		return r;
	endfunction

endpackage

// ===== src/hlrp_chan_if.sv =====
// ============================================================================
// hlrp_chan_if - valid/ready channel
// Carries one payload item per transfer from a source to a sink.
// ============================================================================
interface hlrp_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/host_link_response_parser_unit.sv =====
// ============================================================================
// host_link_response_parser_unit - Host Link C-mode response frame parser
// Parses received characters into response frames and reports the read
// data words and a final status for each frame.
// ============================================================================
// The unit takes one character per transfer on rx and, for each frame that
// ends with CR, sends on tx the decoded read words (good read frames only)
// followed by one status item with last set. A character is taken in every
// cycle while the front end is free; the front end holds off only when the
// buffer bank it is about to fill still holds a frame not yet drained, or
// when the two-entry command queue is full. The command of a finished frame
// is written into the queue on its CR transfer. From there the back end
// takes the command, then for each word reads the buffer and loads the word
// into the output register, and at last loads the status item; each load
// waits while the output register is full and tx is not ready. The word
// buffer has two banks, so one frame can be parsed while the previous one
// drains.
// ============================================================================
module host_link_response_parser_unit
	import hlrp_pkg::*;
#(
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hlrp_chan_if.sink   rx,
	hlrp_chan_if.source tx
);

	// Front end to queue: one command per finished frame.
	logic     push;
	cmd_t     push_cmd;
	logic     q_full;
	// Queue to back end.
	logic     cmd_valid;
	cmd_t     cmd;
	logic     pop;
	// Word writes into the buffer, and the back end's report that a bank
	// has been fully drained and may be refilled.
	word_wr_t wr;
	done_t    done;

	hlrp_front #(
		.MAX_WORDS(MAX_WORDS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.q_full (q_full),
		.done   (done),
		.push   (push),
		.cmd    (push_cmd),
		.wr     (wr)
	);

	hlrp_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head_valid (cmd_valid),
		.head       (cmd),
		.full       (q_full)
	);

	hlrp_back #(
		.MAX_WORDS(MAX_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop),
		.done      (done),
		.tx        (tx)
	);

`ifndef ASSERT_OFF
	// The front end must never write into the bank being drained.
	a_no_bank_clash: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en && cmd_valid |-> wr.bank != cmd.bank)
		else $error("word write into a bank that is still draining");

	// A bank is released only while its command is at the queue head.
	a_done_with_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done.en |-> cmd_valid && pop)
		else $error("bank released without a command being retired");

	// Retiring a command always puts its status item on the output.
	a_pop_gives_status: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> tx.valid && tx.data.last && !tx.data.is_word)
		else $error("command retired without a status transfer");

	// A frame end is never offered to a full queue.
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("frame command pushed into a full queue");
`endif

endmodule

// ===== src/hlrp_front.sv =====
// ============================================================================
// hlrp_front - character parser
// Accepts one character per transfer, tracks the frame, writes decoded words
// into the current buffer bank and posts a command when the frame ends.
// ============================================================================
module hlrp_front
	import hlrp_pkg::*;
#(
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hlrp_chan_if.sink   rx,
	input  logic        q_full,
	input  done_t       done,
	output logic        push,
	output cmd_t        cmd,
	output word_wr_t    wr
);

	phase_t            phase_q, phase_d;
	logic [2:0]        pos_q, pos_d;
	logic [7:0]        xor_q, xor_d;
	logic [15:0]       lag_q, lag_d;
	logic [1:0]        lagcnt_q, lagcnt_d;
	logic              rd_q, rd_d;
	status_t           err_q, err_d;
	logic [11:0]       nib_q, nib_d;
	logic [1:0]        ncnt_q, ncnt_d;
	logic [WCNT_W-1:0] wcnt_q, wcnt_d;
	logic              bank_q, bank_d;
	logic [1:0]        busy_q, busy_d;
	logic              take;

	assign rx.ready = !q_full && !busy_q[bank_q];
	assign take     = rx.valid && rx.ready;

	always_comb begin
		logic [7:0] c;
		logic [7:0] d;
		logic [4:0] hv;
		status_t    e;
		c        = rx.data.rx_char;
		d        = lag_q[15:8];
		hv       = hex_value(d);
		e        = err_q;
		phase_d  = phase_q;
		pos_d    = pos_q;
		xor_d    = xor_q;
		lag_d    = lag_q;
		lagcnt_d = lagcnt_q;
		rd_d     = rd_q;
		err_d    = err_q;
		nib_d    = nib_q;
		ncnt_d   = ncnt_q;
		wcnt_d   = wcnt_q;
		bank_d   = bank_q;
		busy_d   = busy_q;
		push     = 1'b0;
		cmd      = '{bank: bank_q, nwords: wcnt_q, emit: 1'b0, status: ST_READ};
		wr       = '{en: 1'b0, bank: bank_q, idx: wcnt_q, data: {nib_q, hv[3:0]}};

		if (done.en) begin
			busy_d[done.bank] = 1'b0;
		end

		if (take) begin
			if (c == CH_AT) begin
				phase_d  = PH_HEAD;
				pos_d    = 3'd0;
				xor_d    = CH_AT;
				lag_d    = 16'd0;
				lagcnt_d = 2'd0;
				rd_d     = 1'b0;
				err_d    = ST_READ;
				nib_d    = 12'd0;
				ncnt_d   = 2'd0;
				wcnt_d   = '0;
			end else if (phase_q == PH_IDLE) begin
				phase_d = PH_IDLE;
			end else if (c == CH_CR) begin
				if (phase_q != PH_STAR) begin
					e = flag_err(e, ST_FORMAT);
				end else if (e == ST_READ && rd_q && ncnt_q != 2'd0) begin
					e = flag_err(e, ST_LENGTH);
				end
				push       = 1'b1;
				cmd.emit   = (e == ST_READ) && rd_q;
				cmd.status = (e != ST_READ) ? e : (rd_q ? ST_READ : ST_WRITE);
				err_d      = e;
				phase_d    = PH_IDLE;
				busy_d[bank_q] = 1'b1;
				bank_d     = !bank_q;
			end else begin
				unique case (phase_q)
					PH_HEAD: begin
						if (c == CH_STAR) begin
							err_d   = flag_err(err_q, ST_FORMAT);
							phase_d = PH_STAR;
						end else begin
							xor_d = xor_q ^ c;
							case (pos_q)
								3'd0, 3'd1: begin
									if (c != CH_ZERO) err_d = flag_err(err_q, ST_FORMAT);
								end
								3'd2, 3'd4: begin
									lag_d = {8'd0, c};
								end
								3'd3: begin
									if (c == CH_R && lag_q == {8'd0, CH_R}) begin
										rd_d = 1'b1;
									end else if (!(c == CH_R && lag_q == {8'd0, CH_W})) begin
										err_d = flag_err(err_q, ST_HEADER);
									end
								end
								default: begin
									if (c != CH_ZERO || lag_q != {8'd0, CH_ZERO}) begin
										err_d = flag_err(err_q, ST_ENDCODE);
									end
								end
							endcase
							if (pos_q >= 3'd5) begin
								phase_d  = PH_BODY;
								lag_d    = 16'd0;
								lagcnt_d = 2'd0;
							end else begin
								pos_d = pos_q + 3'd1;
							end
						end
					end
					PH_BODY: begin
						if (c == CH_STAR) begin
							if (lagcnt_q < 2'd2) begin
								err_d = flag_err(err_q, ST_FORMAT);
							end else if (lag_q[15:8] != hex_upper(xor_q[7:4]) ||
									lag_q[7:0] != hex_upper(xor_q[3:0])) begin
								err_d = flag_err(err_q, ST_CHECK);
							end
							phase_d = PH_STAR;
						end else begin
							if (lagcnt_q == 2'd2) begin
								// Oldest lagged character is now known to be data
								xor_d = xor_q ^ d;
								if (rd_q) begin
									if (!hv[4]) e = flag_err(e, ST_HEX);
									ncnt_d = ncnt_q + 2'd1;
									nib_d  = {nib_q[7:0], hv[3:0]};
									if (ncnt_q == 2'd3) begin
										nib_d = 12'd0;
										if (wcnt_q < WCNT_W'(MAX_WORDS)) begin
											wr.en  = 1'b1;
											wcnt_d = wcnt_q + 1'b1;
										end else begin
											e = flag_err(e, ST_OVERFLOW);
										end
									end
									err_d = e;
								end
							end else begin
								lagcnt_d = lagcnt_q + 2'd1;
							end
							lag_d = {lag_q[7:0], c};
						end
					end
					PH_STAR: begin
						err_d = flag_err(err_q, ST_FORMAT);
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= 3'd0;
			xor_q    <= 8'd0;
			lag_q    <= 16'd0;
			lagcnt_q <= 2'd0;
			rd_q     <= 1'b0;
			err_q    <= ST_READ;
			nib_q    <= 12'd0;
			ncnt_q   <= 2'd0;
			wcnt_q   <= '0;
			bank_q   <= 1'b0;
			busy_q   <= 2'b00;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			xor_q    <= xor_d;
			lag_q    <= lag_d;
			lagcnt_q <= lagcnt_d;
			rd_q     <= rd_d;
			err_q    <= err_d;
			nib_q    <= nib_d;
			ncnt_q   <= ncnt_d;
			wcnt_q   <= wcnt_d;
			bank_q   <= bank_d;
			busy_q   <= busy_d;
		end
	end

endmodule

// ===== src/hlrp_cmd_fifo.sv =====
// ============================================================================
// hlrp_cmd_fifo - frame-end command queue
// A short first-in first-out queue of finished-frame commands.
// ============================================================================
module hlrp_cmd_fifo
	import hlrp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic head_valid,
	output cmd_t head,
	output logic full
);

	localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

	cmd_t          entry_q [CMDQ_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [PW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign head_valid = count_q != '0;
	assign full       = count_q == (PW+1)'(CMDQ_DEPTH);
	assign head       = entry_q[rptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

endmodule

// ===== src/hlrp_back.sv =====
// ============================================================================
// hlrp_back - result sequencer
// Holds the two-bank word buffer and, per queued command, sends the stored
// words of a good read frame, then the status item, via a registered output.
// ============================================================================
module hlrp_back
	import hlrp_pkg::*;
#(
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  word_wr_t    wr,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        pop,
	output done_t       done,
	hlrp_chan_if.source tx
);

	localparam int IW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int DEPTH = 2 ** (IW + 1);

	logic [15:0]       mem [DEPTH];
	logic [15:0]       rd_data_q;
	back_state_t       state_q, state_d;
	logic [WCNT_W-1:0] cnt_q, cnt_d;
	logic              out_valid_q;
	result_t           out_q;
	logic              out_free;
	logic              rd_en;
	logic              load;
	result_t           load_item;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[{wr.bank, wr.idx[IW-1:0]}] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[{cmd.bank, cnt_q[IW-1:0]}];
		end
	end

	assign out_free = !out_valid_q || tx.ready;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		rd_en     = 1'b0;
		load      = 1'b0;
		pop       = 1'b0;
		done      = '{en: 1'b0, bank: cmd.bank};
		load_item = '{is_word: 1'b0, word_value: 16'd0, word_index: 4'd0,
			status: cmd.status, last: 1'b1};
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cnt_d   = '0;
					state_d = (cmd.emit && cmd.nwords != '0) ? BK_READ : BK_STATUS;
				end
			end
			BK_READ: begin
				rd_en   = 1'b1;
				state_d = BK_LOAD;
			end
			BK_LOAD: begin
				load_item = '{is_word: 1'b1, word_value: rd_data_q,
					word_index: cnt_q[3:0], status: ST_READ, last: 1'b0};
				if (out_free) begin
					load    = 1'b1;
					cnt_d   = cnt_q + 1'b1;
					state_d = (cnt_q + 1'b1 == cmd.nwords) ? BK_STATUS : BK_READ;
				end
			end
			BK_STATUS: begin
				if (out_free) begin
					load    = 1'b1;
					pop     = 1'b1;
					done.en = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= load_item;
		end
	end

	assign tx.valid = out_valid_q;
	assign tx.data  = out_q;

endmodule

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top - regression bench of the Host Link response frame parser
// Feeds response frames, with and without faults, one character per transfer,
// predicts the word and status items of every frame and checks each item that
// leaves the parser, under random idling on both channels.
// ============================================================================
module tb_top
	import hlrp_pkg::*;
();

	// Word buffer depth of the instance under test
	localparam int MAX_W = MAX_WORDS_DEF;
	// Cycle limit of the run, after which the watchdog ends it as a failure
	localparam int unsigned CYCLE_LIMIT = 600000;
	// Characters of frame content to send in all, directed frames included
	localparam int FRAME_CHARS = 430;

	// How a frame is cut short, if at all
	typedef enum logic [1:0] {
		CUT_NONE,
		CUT_EARLY_CR,
		CUT_EARLY_STAR
	} cut_t;

	// Recipe of one frame: its kind, its length and the faults placed in it
	typedef struct {
		bit   write;
		int   nwords;
		bit   bad_prefix;
		bit   bad_header;
		bit   bad_endcode;
		bit   bad_length;
		bit   bad_hex;
		bit   bad_check;
		bit   after_star;
		bit   restart;
		cut_t cut;
	} frame_spec_t;

	logic clk;
	logic arst_n;

	hlrp_chan_if #(.T(rx_item_t)) rx_ch ();
	hlrp_chan_if #(.T(result_t))  tx_ch ();

	host_link_response_parser_unit #(
		.MAX_WORDS(MAX_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.tx    (tx_ch)
	);

	// Value of a hex digit of either case, or -1 for any other character.
	function automatic int digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return int'(c) - int'("0");
		end
		if (c >= "A" && c <= "F") begin
			return int'(c) - int'("A") + 10;
		end
		if (c >= "a" && c <= "f") begin
			return int'(c) - int'("a") + 10;
		end
		return -1;
	endfunction

	// Character of a hex digit, upper case unless asked otherwise.
	function automatic logic [7:0] digit_char(input logic [3:0] n, input bit lower);
		if (n < 4'd10) begin
			return 8'("0") + 8'(n);
		end
		return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
	endfunction

	// ------------------------------------------------------------------------
	// Scoreboard. It mirrors the parser's frame state character by character:
	// every transfer on rx is noted, and at each CR the word items of a good
	// read frame and the closing status item are queued in order. Every
	// transfer on tx is then checked against the oldest queued item.
	// ------------------------------------------------------------------------
	class frame_scoreboard;
		result_t     expected_q[$];
		int          fail_count;

		phase_t      phase;
		logic [2:0]  head_pos;
		logic [7:0]  check_run;
		logic [15:0] lag;
		logic [1:0]  lag_n;
		bit          read_frame;
		bit          err_seen;
		status_t     err;
		logic [15:0] nibbles;
		logic [1:0]  nibble_n;
		logic [15:0] words [MAX_W];
		int          word_n;

		function new();
			fail_count     = 0;
			phase          = PH_IDLE;
			head_pos       = '0;
			check_run      = '0;
			lag            = '0;
			lag_n          = '0;
			read_frame     = 1'b0;
			err_seen       = 1'b0;
			err            = ST_READ;
			nibbles        = '0;
			nibble_n       = '0;
			word_n         = 0;
		endfunction

		task report(input string msg);
			fail_count++;
			if (fail_count <= 40) begin
				$display("ERROR: %s", msg);
			end
		endtask

		// The lowest error code of a frame wins.
		function void raise(input status_t code);
			if (!err_seen || code < err) begin
				err = code;
			end
			err_seen = 1'b1;
		endfunction

		function void open_frame();
			phase      = PH_HEAD;
			head_pos   = '0;
			check_run  = CH_AT;
			lag        = '0;
			lag_n      = '0;
			read_frame = 1'b0;
			err_seen   = 1'b0;
			err        = ST_READ;
			nibbles    = '0;
			nibble_n   = '0;
			word_n     = 0;
		endfunction

		// A data character that has left the lag: it enters the check and,
		// in a read frame, the current word.
		function void absorb_data(input logic [7:0] c);
			int v;
			check_run ^= c;
			if (!read_frame) begin
				return;
			end
			v = digit_value(c);
			if (v < 0) begin
				raise(ST_HEX);
				v = 0;
			end
			nibbles  = {nibbles[11:0], 4'(v)};
			nibble_n = nibble_n + 2'd1;
			if (nibble_n == 2'd0) begin
				if (word_n < MAX_W) begin
					words[word_n] = nibbles;
					word_n++;
				end else begin
					raise(ST_OVERFLOW);
				end
				nibbles = '0;
			end
		endfunction

		task note_char(input logic [7:0] c);
			result_t r;
			int      i;
			if (c == CH_AT) begin
				open_frame();
				return;
			end
			if (phase == PH_IDLE) begin
				return;
			end
			if (c == CH_CR) begin
				if (phase != PH_STAR) begin
					raise(ST_FORMAT);
				end else if (!err_seen && read_frame && nibble_n != 2'd0) begin
					raise(ST_LENGTH);
				end
				if (!err_seen && read_frame) begin
					for (i = 0; i < word_n; i++) begin
						r.is_word    = 1'b1;
						r.word_value = words[i];
						r.word_index = 4'(i);
						r.status     = ST_READ;
						r.last       = 1'b0;
						expected_q.push_back(r);
					end
				end
				r.is_word    = 1'b0;
				r.word_value = '0;
				r.word_index = '0;
				r.status     = err_seen ? err : (read_frame ? ST_READ : ST_WRITE);
				r.last       = 1'b1;
				expected_q.push_back(r);
				phase = PH_IDLE;
				return;
			end
			case (phase)
				PH_HEAD: begin
					if (c == CH_STAR) begin
						raise(ST_FORMAT);
						phase = PH_STAR;
						return;
					end
					check_run ^= c;
					case (head_pos)
						3'd0, 3'd1: begin
							if (c != CH_ZERO) raise(ST_FORMAT);
						end
						3'd2, 3'd4: begin
							lag = {8'h00, c};
						end
						3'd3: begin
							if (c == CH_R && lag[7:0] == CH_R) begin
								read_frame = 1'b1;
							end else if (!(c == CH_R && lag[7:0] == CH_W)) begin
								raise(ST_HEADER);
							end
						end
						default: begin
							if (c != CH_ZERO || lag[7:0] != CH_ZERO) raise(ST_ENDCODE);
						end
					endcase
					if (head_pos >= 3'd5) begin
						phase = PH_BODY;
						lag   = '0;
						lag_n = '0;
					end else begin
						head_pos++;
					end
				end
				PH_BODY: begin
					if (c == CH_STAR) begin
						if (lag_n < 2'd2) begin
							raise(ST_FORMAT);
						end else if (lag[15:8] != digit_char(check_run[7:4], 1'b0) ||
						             lag[7:0] != digit_char(check_run[3:0], 1'b0)) begin
							raise(ST_CHECK);
						end
						phase = PH_STAR;
						return;
					end
					if (lag_n == 2'd2) begin
						absorb_data(lag[15:8]);
					end else begin
						lag_n++;
					end
					lag = {lag[7:0], c};
				end
				default: begin
					raise(ST_FORMAT);
				end
			endcase
		endtask

		task check_result(input result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result: word=%0b value=%h index=%0d status=%0d last=%0b",
					got.is_word, got.word_value, got.word_index, got.status, got.last));
				return;
			end
			want = expected_q.pop_front();
			if (got.is_word !== want.is_word) begin
				report($sformatf("is_word %0b, expected %0b", got.is_word, want.is_word));
			end
			if (got.word_value !== want.word_value) begin
				report($sformatf("word_value %h, expected %h (index %0d)",
					got.word_value, want.word_value, want.word_index));
			end
			if (got.word_index !== want.word_index) begin
				report($sformatf("word_index %0d, expected %0d", got.word_index, want.word_index));
			end
			if (got.status !== want.status) begin
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			end
			if (got.last !== want.last) begin
				report($sformatf("last %0b, expected %0b", got.last, want.last));
			end
		endtask
	endclass

	frame_scoreboard sb = new();

	logic [7:0]  frame_q[$];
	bit          src_calm;
	bit          sink_calm;
	int          frame_chars;
	int unsigned cycle_count = 0;

	// Clock. Reset is applied once, at the start of the main sequence.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Idle length between transfers: mostly none, sometimes a short gap and
	// now and then a long pause. In a calm stretch there is no idling at all.
	function automatic int idle_gap(input bit calm);
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 40);
	endfunction

	// Any character that neither opens a frame nor stands for '*' or CR,
	// optionally also excluding hex digits.
	function automatic logic [7:0] any_byte(input bit no_hex);
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == CH_AT || c == CH_CR || c == CH_STAR ||
		           (no_hex && digit_value(c) >= 0));
		return c;
	endfunction

	function automatic frame_spec_t clean_spec(input bit write, input int nwords);
		frame_spec_t s;
		s.write       = write;
		s.nwords      = nwords;
		s.bad_prefix  = 1'b0;
		s.bad_header  = 1'b0;
		s.bad_endcode = 1'b0;
		s.bad_length  = 1'b0;
		s.bad_hex     = 1'b0;
		s.bad_check   = 1'b0;
		s.after_star  = 1'b0;
		s.restart     = 1'b0;
		s.cut         = CUT_NONE;
		return s;
	endfunction

	// Random frame: mostly short well-formed frames with random data, some
	// long ones, a few overflowing, and about a third carrying faults.
	function automatic frame_spec_t random_spec();
		frame_spec_t s;
		int          r;
		int          n;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			n = $urandom_range(0, 4);
		end else if (r < 95) begin
			n = $urandom_range(5, MAX_W);
		end else begin
			n = $urandom_range(MAX_W + 1, MAX_W + 2);
		end
		s = clean_spec($urandom_range(0, 3) == 0, n);
		s.restart = ($urandom_range(0, 9) == 0);
		if ($urandom_range(0, 99) < 35) begin
			s.bad_prefix  = ($urandom_range(0, 5) == 0);
			s.bad_header  = ($urandom_range(0, 4) == 0);
			s.bad_endcode = ($urandom_range(0, 4) == 0);
			s.bad_length  = ($urandom_range(0, 3) == 0);
			s.bad_hex     = ($urandom_range(0, 3) == 0);
			s.bad_check   = ($urandom_range(0, 3) == 0);
			s.after_star  = ($urandom_range(0, 5) == 0);
			r = $urandom_range(0, 5);
			s.cut = (r == 0) ? CUT_EARLY_CR : (r == 1) ? CUT_EARLY_STAR : CUT_NONE;
		end
		return s;
	endfunction

	// Builds the characters of one frame in frame_q. The frame check is the
	// XOR of everything from '@' to the last data character, as the parser
	// expects it, and is then spoilt on purpose where the recipe says so.
	function automatic void make_frame(input frame_spec_t s);
		logic [7:0] fcs;
		logic [7:0] c1;
		logic [7:0] c2;
		int         ndig;
		int         bad_at;
		int         cut;
		int         i;
		frame_q.delete();
		frame_q.push_back(CH_AT);
		frame_q.push_back(CH_ZERO);
		frame_q.push_back(CH_ZERO);
		if (s.bad_prefix) begin
			frame_q[$urandom_range(1, 2)] = any_byte(1'b0);
		end
		// Header: near misses such as RW or WW as well as arbitrary bytes
		if (s.bad_header) begin
			if ($urandom_range(0, 1) == 1) begin
				c1 = ($urandom_range(0, 1) == 1) ? CH_R : CH_W;
				c2 = CH_W;
			end else begin
				c1 = any_byte(1'b0);
				c2 = any_byte(1'b0);
				if (c2 == CH_R && (c1 == CH_R || c1 == CH_W)) c2 = CH_W;
			end
		end else begin
			c1 = s.write ? CH_W : CH_R;
			c2 = CH_R;
		end
		frame_q.push_back(c1);
		frame_q.push_back(c2);
		// End code: a nonzero one has at least one digit other than '0'
		if (s.bad_endcode) begin
			c1 = digit_char(4'($urandom_range(0, 15)), 1'b0);
			c2 = digit_char(4'($urandom_range(1, 15)), 1'b0);
			if ($urandom_range(0, 1) == 1) begin
				frame_q.push_back(c2);
				frame_q.push_back(c1);
			end else begin
				frame_q.push_back(c1);
				frame_q.push_back(c2);
			end
		end else begin
			frame_q.push_back(CH_ZERO);
			frame_q.push_back(CH_ZERO);
		end
		// Data: arbitrary bytes in a write frame, hex words of mixed case in
		// a read frame
		if (s.write) begin
			ndig = $urandom_range(0, 10);
			for (i = 0; i < ndig; i++) begin
				frame_q.push_back(any_byte(1'b0));
			end
		end else begin
			ndig = s.nwords * 4;
			if (s.bad_length) ndig += $urandom_range(1, 3);
			bad_at = (s.bad_hex && ndig > 0) ? $urandom_range(0, ndig - 1) : -1;
			for (i = 0; i < ndig; i++) begin
				frame_q.push_back((i == bad_at) ? any_byte(1'b1) :
					digit_char(4'($urandom_range(0, 15)), $urandom_range(0, 1) == 1));
			end
		end
		fcs = '0;
		foreach (frame_q[i]) begin
			fcs ^= frame_q[i];
		end
		if (s.bad_check) fcs ^= 8'($urandom_range(1, 255));
		frame_q.push_back(digit_char(fcs[7:4], 1'b0));
		frame_q.push_back(digit_char(fcs[3:0], 1'b0));
		frame_q.push_back(CH_STAR);
		// A star inside the header or too soon after the end code
		if (s.cut == CUT_EARLY_STAR) begin
			cut = $urandom_range(1, 8);
			while (frame_q.size() > cut) void'(frame_q.pop_back());
			frame_q.push_back(CH_STAR);
		end
		// CR anywhere before the star
		if (s.cut == CUT_EARLY_CR) begin
			cut = $urandom_range(1, frame_q.size() - 1);
			while (frame_q.size() > cut) void'(frame_q.pop_back());
		end else if (s.after_star) begin
			repeat ($urandom_range(1, 2)) frame_q.push_back(any_byte(1'b0));
		end
		frame_q.push_back(CH_CR);
		// An abandoned frame in front, dropped silently by the next '@'
		if (s.restart) begin
			repeat ($urandom_range(0, 6)) frame_q.push_front(any_byte(1'b0));
			frame_q.push_front(CH_AT);
		end
	endfunction

	// Drives one character and waits for its transfer. Valid is left high
	// afterwards, so back-to-back characters need no extra assignment.
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = idle_gap(src_calm);
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.data  <= rx_item_t'(c);
		do begin
			@(posedge clk);
		end while (!rx_ch.ready);
	endtask

	// Sends one frame. Each frame also decides afresh whether either side
	// runs without idling for its length.
	task automatic run_frame(input frame_spec_t s);
		make_frame(s);
		src_calm  = ($urandom_range(0, 3) == 0);
		sink_calm = ($urandom_range(0, 3) == 0);
		foreach (frame_q[i]) begin
			send_char(frame_q[i]);
		end
		frame_chars += frame_q.size();
	endtask

	// Receiver: ready drops for random stretches between bursts of
	// acceptance, so that stalls land on every step of the drain.
	initial begin
		int gap;
		tx_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			gap = idle_gap(sink_calm);
			if (gap > 0) begin
				tx_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tx_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Both monitors sample at the rising edge, where a transfer takes place.
	always @(posedge clk) begin
		if (arst_n && rx_ch.valid && rx_ch.ready) begin
			sb.note_char(rx_ch.data.rx_char);
		end
	end

	always @(posedge clk) begin
		if (arst_n && tx_ch.valid && tx_ch.ready) begin
			sb.check_result(tx_ch.data);
		end
	end

	// Main sequence: directed characters and frames first, then random frames with noise in
	// between, then a wait for the last items to drain.
	initial begin
		frame_spec_t s;
		int          k;
		src_calm    = 1'b0;
		sink_calm   = 1'b0;
		frame_chars = 0;
		arst_n      = 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Characters outside a frame, CR among them, are ignored; the two
		// extreme codes go through here as well.
		send_char(8'h00);
		send_char(8'hFF);
		send_char(CH_CR);
		send_char(CH_STAR);

		// One frame for each status, plus the corner cases of the format:
		// empty and full read frames, overflow, a frame with several faults
		// to show that the lowest code wins, and the various early ends.
		for (k = 0; k < 17; k++) begin
			s = clean_spec(1'b0, 1);
			case (k)
				0:  s.nwords = 0;
				1:  s.nwords = 1;
				2:  s.nwords = MAX_W;
				3:  s.write = 1'b1;
				4:  s.nwords = MAX_W + 1;
				5:  s.bad_length = 1'b1;
				6:  s.bad_hex = 1'b1;
				7:  s.bad_check = 1'b1;
				8:  s.bad_endcode = 1'b1;
				9:  s.bad_header = 1'b1;
				10: s.bad_prefix = 1'b1;
				11: s.cut = CUT_EARLY_CR;
				12: s.cut = CUT_EARLY_STAR;
				13: s.after_star = 1'b1;
				14: s.restart = 1'b1;
				15: begin
					s.nwords      = 2;
					s.bad_header  = 1'b1;
					s.bad_endcode = 1'b1;
					s.bad_check   = 1'b1;
					s.bad_length  = 1'b1;
					s.bad_hex     = 1'b1;
				end
				default: begin
					s.nwords      = 2;
					s.bad_check   = 1'b1;
					s.bad_length  = 1'b1;
				end
			endcase
			run_frame(s);
		end

		// Random part: runs until the character budget of the whole run has
		// been spent.
		while (frame_chars < FRAME_CHARS) begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
			end
			run_frame(random_spec());
		end
		rx_ch.valid <= 1'b0;

		while (sb.expected_q.size() != 0) begin
			@(posedge clk);
		end
		// Allow for any stray item still in flight
		repeat (60) @(posedge clk);

		if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
